[sv/pct_pkg.sv]
// ----------------------------------------------------------------------------
// pct_pkg: shared types and constants of the command-line tokenizer
// Item, result and flag structs, result kinds, status codes, characters, queue size.
// ----------------------------------------------------------------------------
`default_nettype none

package pct_pkg;

    localparam logic [1:0] KIND_BYTE   = 2'd0;
    localparam logic [1:0] KIND_END    = 2'd1;
    localparam logic [1:0] KIND_FINISH = 2'd2;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_DANGLING = 2'd1;
    localparam logic [1:0] STATUS_UNCLOSED = 2'd2;

    localparam logic [7:0] CH_SQUOTE  = 8'h27;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;

    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

    typedef struct packed {
        logic       action;
        logic [7:0] ch;
    } item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic [1:0] status;
        logic       last;
    } result_t;

    typedef struct packed {
        logic in_word;
        logic single_quoted;
        logic double_quoted;
        logic escape_pending;
    } flags_t;

endpackage

`default_nettype wire

[sv/posix_cmdline_tokenizer_unit.sv]
// An item is held in the input register; its results are written into the result queue.
// Items are taken one per cycle while the result queue has room for two more
// results; items with two results fill the queue faster than it drains.
// Input ready depends only on the input register and the result queue fill.
// Reset clears the quoting flags, the input register valid flag and the result queue count and pointers.
// ----------------------------------------------------------------------------
// posix_cmdline_tokenizer_unit: POSIX shell word splitter
// Registers an item, runs one tokenizer step, queues its results.
// ----------------------------------------------------------------------------
`default_nettype none

module posix_cmdline_tokenizer_unit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  pct_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_ready,
    output pct_pkg::result_t result
);
    import pct_pkg::*;

    item_t      item_reg;
    logic       item_valid_reg, item_valid_next;
    flags_t     flags_reg, flags_next, step_flags;
    logic [1:0] step_count, push_count;
    result_t    res0, res1;
    logic       room, advance;

    assign advance    = item_valid_reg && room;
    assign item_ready = !item_valid_reg || advance;
    assign push_count = advance ? step_count : 2'd0;

    pct_step u_step (
        .item       (item_reg),
        .flags      (flags_reg),
        .flags_next (step_flags),
        .count      (step_count),
        .res0       (res0),
        .res1       (res1)
    );

    pct_outq u_outq (
        .clk          (clk),
        .rst_n        (rst_n),
        .push_count   (push_count),
        .push0        (res0),
        .push1        (res1),
        .room         (room),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always_comb
    begin
        flags_next      = advance ? step_flags : flags_reg;
        item_valid_next = item_ready ? item_valid : item_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
            item_reg <= item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            flags_reg      <= '0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            flags_reg      <= flags_next;
        end
    end

endmodule

`default_nettype wire

[sv/pct_step.sv]
// ----------------------------------------------------------------------------
// pct_step: one tokenizer step
// Decodes one item against the quoting flags; gives next flags and up to two
// results.
// ----------------------------------------------------------------------------
`default_nettype none

module pct_step (
    input  pct_pkg::item_t   item,
    input  pct_pkg::flags_t  flags,
    output pct_pkg::flags_t  flags_next,
    output logic [1:0]       count,
    output pct_pkg::result_t res0,
    output pct_pkg::result_t res1
);
    import pct_pkg::*;

    logic       blank;
    logic [7:0] c;
    logic [1:0] st;

    assign c     = item.ch;
    assign blank = (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});

    always_comb
    begin
        flags_next = flags;
        count      = 2'd0;
        res0       = '0;
        res1       = '0;
        st         = STATUS_OK;
        if (item.action)
        begin
            if (flags.escape_pending)
                st = STATUS_DANGLING;
            else if (flags.single_quoted || flags.double_quoted)
                st = STATUS_UNCLOSED;
            if (flags.in_word)
            begin
                res0.kind   = KIND_END;
                res1.kind   = KIND_FINISH;
                res1.status = st;
                count       = 2'd2;
            end
            else
            begin
                res0.kind   = KIND_FINISH;
                res0.status = st;
                count       = 2'd1;
            end
            flags_next = '0;
        end
        else if (flags.in_word || !blank)
        begin
            flags_next.in_word = 1'b1;
            if (blank && !flags.single_quoted && !flags.double_quoted
                && !flags.escape_pending)
            begin
                flags_next.in_word = 1'b0;
                res0.kind          = KIND_END;
                count              = 2'd1;
            end
            else if (flags.single_quoted)
            begin
                if (c == CH_SQUOTE)
                    flags_next.single_quoted = 1'b0;
                else
                begin
                    res0.out_byte = c;
                    count         = 2'd1;
                end
            end
            else if (flags.escape_pending)
            begin
                flags_next.escape_pending = 1'b0;
                // backslash-newline vanishes; double quotes keep it unless \ or "
                if (c == CH_NEWLINE)
                    count = 2'd0;
                else if (flags.double_quoted && c != CH_BSLASH && c != CH_DQUOTE)
                begin
                    res0.out_byte = CH_BSLASH;
                    res1.out_byte = c;
                    count         = 2'd2;
                end
                else
                begin
                    res0.out_byte = c;
                    count         = 2'd1;
                end
            end
            else if (c == CH_BSLASH)
                flags_next.escape_pending = 1'b1;
            else if (flags.double_quoted)
            begin
                if (c == CH_DQUOTE)
                    flags_next.double_quoted = 1'b0;
                else
                begin
                    res0.out_byte = c;
                    count         = 2'd1;
                end
            end
            else if (c == CH_SQUOTE)
                flags_next.single_quoted = 1'b1;
            else if (c == CH_DQUOTE)
                flags_next.double_quoted = 1'b1;
            else
            begin
                res0.out_byte = c;
                count         = 2'd1;
            end
        end
        // mark the final result of this item
        if (count == 2'd1)
            res0.last = 1'b1;
        else if (count == 2'd2)
            res1.last = 1'b1;
    end

endmodule

`default_nettype wire

[sv/pct_outq.sv]
// ----------------------------------------------------------------------------
// pct_outq: result queue
// Takes up to two results per cycle, hands one per transfer to the output.
// ----------------------------------------------------------------------------
`default_nettype none

module pct_outq (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [1:0]       push_count,
    input  pct_pkg::result_t push0,
    input  pct_pkg::result_t push1,
    output logic             room,
    output logic             result_valid,
    input  logic             result_ready,
    output pct_pkg::result_t result
);
    import pct_pkg::*;

    result_t                  mem [OUTQ_DEPTH];
    logic [OUTQ_AW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [OUTQ_AW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [OUTQ_CW-1:0]       count_reg, count_next;
    logic                     pop;

    // two free entries guaranteed, so no path from output ready
    assign room         = (count_reg <= OUTQ_CW'(OUTQ_DEPTH - 2));
    assign result_valid = (count_reg != '0);
    assign result       = mem[rd_ptr_reg];
    assign pop          = result_valid && result_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + OUTQ_AW'(push_count);
        rd_ptr_next = rd_ptr_reg + OUTQ_AW'(pop);
        count_next  = count_reg + OUTQ_CW'(push_count) - OUTQ_CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
            mem[wr_ptr_reg] <= push0;
        if (push_count == 2'd2)
            mem[wr_ptr_reg + OUTQ_AW'(1)] <= push1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

[sv/pct_chk.sv]
// ----------------------------------------------------------------------------
// pct_chk: port checker for the tokenizer
// Watches result transfers for kind/field consistency and ordering.
// ----------------------------------------------------------------------------
`default_nettype none

module pct_chk (
    input logic             clk,
    input logic             rst_n,
    input logic             result_valid,
    input logic             result_ready,
    input pct_pkg::result_t result
);
    import pct_pkg::*;

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.kind == KIND_BYTE || result.kind == KIND_END
                          || result.kind == KIND_FINISH))
        else $error("result kind out of range");

    a_finish_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.kind == KIND_FINISH) |-> result.last)
        else $error("finish result not marked last");

    a_nonbyte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.kind != KIND_BYTE) |-> (result.out_byte == 8'd0))
        else $error("byte field set on a marker");

    // an end marker not marked last comes from a finish item
    a_end_then_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_ready && result.kind == KIND_END && !result.last)
        |=> (result_valid && result.kind == KIND_FINISH))
        else $error("split end marker without finish");

endmodule

bind posix_cmdline_tokenizer_unit pct_chk u_pct_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

`default_nettype wire

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: testbench of the POSIX command-line tokenizer
// Drives a short table of hand-picked bytes and finish items, then random
// command lines, under changing sender gaps and receiver stalls. A local
// word-splitting model predicts the results of untyped rows and random items;
// typed rows carry their own. Each result transfer is checked in order against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

    import pct_pkg::*;

    localparam int NUM_DIRECTED = 26;
    localparam int NUM_RANDOM   = 2000;
    localparam int PHASE_ITEMS  = 125;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 500000;

    localparam result_t NO_RES = '0;

    // One stimulus row; typed rows carry their own expected results.
    typedef struct packed {
        item_t      it;
        logic       typed;
        logic [1:0] n;
        result_t    r0;
        result_t    r1;
    } row_t;

    localparam row_t DIRECTED [NUM_DIRECTED] = '{
        '{item_t'{1'b1, 8'h00}, 1'b1, 2'd1,
          result_t'{KIND_FINISH, 8'h00, STATUS_OK, 1'b1}, NO_RES},
        '{item_t'{1'b0, 8'h61}, 1'b1, 2'd1,
          result_t'{KIND_BYTE, 8'h61, STATUS_OK, 1'b1}, NO_RES},
        '{item_t'{1'b0, 8'hFF}, 1'b1, 2'd1,
          result_t'{KIND_BYTE, 8'hFF, STATUS_OK, 1'b1}, NO_RES},
        '{item_t'{1'b0, CH_SPACE}, 1'b1, 2'd1,
          result_t'{KIND_END, 8'h00, STATUS_OK, 1'b1}, NO_RES},
        '{item_t'{1'b0, CH_SPACE}, 1'b1, 2'd0, NO_RES, NO_RES},
        '{item_t'{1'b0, 8'h00}, 1'b1, 2'd1,
          result_t'{KIND_BYTE, 8'h00, STATUS_OK, 1'b1}, NO_RES},
        '{item_t'{1'b0, CH_CR}, 1'b1, 2'd1,
          result_t'{KIND_END, 8'h00, STATUS_OK, 1'b1}, NO_RES},
        // empty argument from a pair of double quotes
        '{item_t'{1'b0, CH_DQUOTE}, 1'b0, 2'd0, NO_RES, NO_RES},
        '{item_t'{1'b0, CH_DQUOTE}, 1'b0, 2'd0, NO_RES, NO_RES},
        '{item_t'{1'b0, CH_TAB}, 1'b0, 2'd0, NO_RES, NO_RES},
        // single quotes keep backslash and whitespace literal
        '{item_t'{1'b0, CH_SQUOTE}, 1'b0, 2'd0, NO_RES, NO_RES},
        '{item_t'{1'b0, CH_BSLASH}, 1'b0, 2'd0, NO_RES, NO_RES},
        '{item_t'{1'b0, 8'h0C}, 1'b0, 2'd0, NO_RES, NO_RES},
        '{item_t'{1'b0, CH_SQUOTE}, 1'b0, 2'd0, NO_RES, NO_RES},
        // backslash in double quotes: kept before 'n', dropped before a quote
        '{item_t'{1'b0, CH_DQUOTE}, 1'b0, 2'd0, NO_RES, NO_RES},
        '{item_t'{1'b0, CH_BSLASH}, 1'b0, 2'd0, NO_RES, NO_RES},
        '{item_t'{1'b0, 8'h6E}, 1'b0, 2'd0, NO_RES, NO_RES},
        '{item_t'{1'b0, CH_BSLASH}, 1'b0, 2'd0, NO_RES, NO_RES},
        '{item_t'{1'b0, CH_DQUOTE}, 1'b0, 2'd0, NO_RES, NO_RES},
        '{item_t'{1'b0, CH_DQUOTE}, 1'b0, 2'd0, NO_RES, NO_RES},
        // line continuation, then a dangling backslash
        '{item_t'{1'b0, CH_BSLASH}, 1'b0, 2'd0, NO_RES, NO_RES},
        '{item_t'{1'b0, CH_NEWLINE}, 1'b0, 2'd0, NO_RES, NO_RES},
        '{item_t'{1'b0, CH_BSLASH}, 1'b0, 2'd0, NO_RES, NO_RES},
        '{item_t'{1'b1, 8'hFF}, 1'b1, 2'd2,
          result_t'{KIND_END, 8'h00, STATUS_OK, 1'b0},
          result_t'{KIND_FINISH, 8'h00, STATUS_DANGLING, 1'b1}},
        '{item_t'{1'b0, CH_DQUOTE}, 1'b0, 2'd0, NO_RES, NO_RES},
        '{item_t'{1'b1, 8'h00}, 1'b1, 2'd2,
          result_t'{KIND_END, 8'h00, STATUS_OK, 1'b0},
          result_t'{KIND_FINISH, 8'h00, STATUS_UNCLOSED, 1'b1}}
    };

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_ready;
    item_t   item;
    logic    result_valid;
    logic    result_ready;
    result_t result;

    logic    item_taken = 1'b0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    int      errors = 0;
    int      cycle_count = 0;
    flags_t  shell_flags = '0;
    result_t expected_results [$];
    result_t next_expected;

    posix_cmdline_tokenizer_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Word splitter: advance the quoting flags by one item, return its results.
    function automatic int tokenize_step(input item_t it, output result_t res [2]);
        logic [7:0] c;
        logic       blank;
        int         n;
        c = it.ch;
        blank = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
        n = 0;
        res[0] = '0;
        res[1] = '0;
        if (it.action) begin
            if (shell_flags.in_word) begin
                res[n].kind = KIND_END;
                n++;
            end
            res[n].kind = KIND_FINISH;
            if (shell_flags.escape_pending)
                res[n].status = STATUS_DANGLING;
            else if (shell_flags.single_quoted || shell_flags.double_quoted)
                res[n].status = STATUS_UNCLOSED;
            else
                res[n].status = STATUS_OK;
            n++;
            shell_flags = '0;
        end else if (shell_flags.in_word || !blank) begin
            shell_flags.in_word = 1'b1;
            if (blank && !shell_flags.single_quoted && !shell_flags.double_quoted
                    && !shell_flags.escape_pending) begin
                shell_flags.in_word = 1'b0;
                res[0].kind = KIND_END;
                n = 1;
            end else if (shell_flags.single_quoted) begin
                if (c == CH_SQUOTE)
                    shell_flags.single_quoted = 1'b0;
                else begin
                    res[0].out_byte = c;
                    n = 1;
                end
            end else if (shell_flags.escape_pending) begin
                shell_flags.escape_pending = 1'b0;
                if (c == CH_NEWLINE)
                    n = 0;
                else if (shell_flags.double_quoted && c != CH_BSLASH && c != CH_DQUOTE)
                begin
                    res[0].out_byte = CH_BSLASH;
                    res[1].out_byte = c;
                    n = 2;
                end else begin
                    res[0].out_byte = c;
                    n = 1;
                end
            end else if (c == CH_BSLASH)
                shell_flags.escape_pending = 1'b1;
            else if (shell_flags.double_quoted) begin
                if (c == CH_DQUOTE)
                    shell_flags.double_quoted = 1'b0;
                else begin
                    res[0].out_byte = c;
                    n = 1;
                end
            end else if (c == CH_SQUOTE)
                shell_flags.single_quoted = 1'b1;
            else if (c == CH_DQUOTE)
                shell_flags.double_quoted = 1'b1;
            else begin
                res[0].out_byte = c;
                n = 1;
            end
        end
        if (n > 0)
            res[n - 1].last = 1'b1;
        return n;
    endfunction

    // Command-line bytes weighted toward quoting and escapes, a finish now and then.
    function automatic item_t random_item();
        item_t it;
        int    r;
        int    sel;
        r = $urandom_range(99);
        it.action = 1'b0;
        it.ch = 8'($urandom_range(255));
        if (r < 3)
            it.action = 1'b1;
        else if (r < 18) begin
            sel = $urandom_range(5);
            it.ch = (sel == 5) ? CH_SPACE : CH_TAB + 8'(sel);
        end else if (r < 28)
            it.ch = CH_SQUOTE;
        else if (r < 38)
            it.ch = CH_DQUOTE;
        else if (r < 50)
            it.ch = CH_BSLASH;
        else if (r < 55)
            it.ch = CH_NEWLINE;
        return it;
    endfunction

    // Call at a falling edge; returns at the falling edge after the transfer.
    task automatic transfer_item(input item_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            item_valid = 1'b0;
            @(negedge clk);
        end
        item_valid = 1'b1;
        item = it;
        @(negedge clk);
        while (!item_taken)
            @(negedge clk);
    endtask

    always @(posedge clk)
        item_taken <= item_valid && item_ready;

    initial
    begin
        result_ready = 1'b0;
        forever begin
            @(negedge clk);
            result_ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready) begin
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result kind=%0d byte=%02h status=%0d last=%0d",
                         $time, result.kind, result.out_byte, result.status, result.last);
            end else begin
                next_expected = expected_results.pop_front();
                if (result !== next_expected) begin
                    errors++;
                    $display("%0t: expected kind=%0d byte=%02h status=%0d last=%0d, %s",
                             $time, next_expected.kind, next_expected.out_byte,
                             next_expected.status, next_expected.last, "mismatch:");
                    $display("%0t:   actual kind=%0d byte=%02h status=%0d last=%0d",
                             $time, result.kind, result.out_byte, result.status,
                             result.last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial
    begin
        item_t   it;
        result_t res [2];
        int      n;
        int      phase;
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int k = 0; k < NUM_DIRECTED + NUM_RANDOM; k++) begin
            // rotate: no idling, sender gaps, receiver stalls, both
            phase = (k / PHASE_ITEMS) % 4;
            send_idle_pct  = (phase == 1) ? 71 : (phase == 3) ? 36 : 0;
            recv_stall_pct = (phase == 2) ? 71 : (phase == 3) ? 36 : 0;
            it = (k < NUM_DIRECTED) ? DIRECTED[k].it : random_item();
            transfer_item(it);
            n = tokenize_step(it, res);
            if (k < NUM_DIRECTED && DIRECTED[k].typed) begin
                n = DIRECTED[k].n;
                res[0] = DIRECTED[k].r0;
                res[1] = DIRECTED[k].r1;
            end
            // append each prediction at the tail of the queue
            for (int i = 0; i < n; i++)
                expected_results = {expected_results, res[i]};
        end
        item_valid = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;

        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
